/* rtl/qvr_pkg.sv */
// qvr_pkg: constants and types shared by the quaternion vector rotate block.
// No dependencies; compile first.
package qvr_pkg;

    // Quaternion components are signed Q2.14
    localparam int QUAT_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    // Scale of the double product (2^14 * 2^14)
    localparam int FRAC_SHIFT      = 28;
    localparam int PIPE_STAGES     = 5;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } cfg_reg_t;

    // Reset quaternion is identity (1.0 in Q2.14)
    localparam logic signed [QUAT_WIDTH-1:0] QUAT_W_RESET = 16'sd16384;
    localparam logic signed [QUAT_WIDTH-1:0] QUAT_V_RESET = 16'sd0;

endpackage

/* rtl/qvr_in_if.sv */
// qvr_in_if: valid/ready channel carrying one input vector word.
// Depends on nothing; width follows DATA_WIDTH.
interface qvr_in_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
    logic signed [DATA_WIDTH-1:0] vec_w;

    modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

/* rtl/qvr_out_if.sv */
// qvr_out_if: valid/ready channel carrying one rotated vector word.
// Depends on nothing; width follows DATA_WIDTH.
interface qvr_out_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic signed [DATA_WIDTH-1:0] pass_w;
    logic                         clipped;

    modport source (output valid, rot_x, rot_y, rot_z, pass_w, clipped, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, pass_w, clipped, output ready);
endinterface

/* rtl/quaternion_vector_rotate.sv */
// Channel   | Dir | Payload                                   | Handshake
// vec_in    | in  | vec_x, vec_y, vec_z, vec_w                | valid/ready
// rot_out   | out | rot_x, rot_y, rot_z, pass_w, clipped      | valid/ready
// cfg       | in  | cfg_index, cfg_data (quat_w/x/y/z)        | cfg_we, no wait
//
// One word per clock while rot_out is not stalled; each accepted word passes every stage to rot_out.valid.
// Stages: q*v products, t sums, t*conj(q) products, wide sums, round/saturate.
// The throughput is set by the five-stage pipeline, each stage taking a word
// every cycle. A stall on rot_out freezes all stages at once; vec_in.ready is
// low only while the output holds a word that is not taken. rst_n clears the
// stage valid bits and loads the identity quaternion.
// Depends on qvr_pkg, qvr_in_if, qvr_out_if.
module quaternion_vector_rotate #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [qvr_pkg::QUAT_WIDTH-1:0]         cfg_data,
    qvr_in_if.sink                                 vec_in,
    qvr_out_if.source                              rot_out
);

    localparam int QW = qvr_pkg::QUAT_WIDTH;
    localparam int PW = QW + DATA_WIDTH;      // q*v product
    localparam int TW = PW + 2;               // sum of three products
    localparam int RW = TW + QW;              // t*q product
    localparam int AW = RW + 2;               // sum of four products
    localparam int SW = AW - qvr_pkg::FRAC_SHIFT;
    localparam int NS = qvr_pkg::PIPE_STAGES;

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (qvr_pkg::FRAC_SHIFT - 1);
    localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    // Configuration registers
    logic signed [QW-1:0] quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;

    // Pipeline control
    logic [NS-1:0] valid_reg;
    logic          advance;

    // Stage payloads
    logic signed [PW-1:0]         p_reg  [12];
    logic signed [PW-1:0]         p_next [12];
    logic signed [TW-1:0]         t_reg  [4];
    logic signed [TW-1:0]         t_next [4];
    logic signed [RW-1:0]         m_reg  [12];
    logic signed [RW-1:0]         m_next [12];
    logic signed [AW-1:0]         acc_reg  [3];
    logic signed [AW-1:0]         acc_next [3];
    logic signed [DATA_WIDTH-1:0] rot_reg  [3];
    logic signed [DATA_WIDTH-1:0] rot_next [3];
    logic                         clip_reg, clip_next;
    logic signed [DATA_WIDTH-1:0] w_reg  [NS];

    // Write quaternion registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg <= qvr_pkg::QUAT_W_RESET;
            quat_x_reg <= qvr_pkg::QUAT_V_RESET;
            quat_y_reg <= qvr_pkg::QUAT_V_RESET;
            quat_z_reg <= qvr_pkg::QUAT_V_RESET;
        end
        else if (cfg_we)
        begin
            case (qvr_pkg::cfg_reg_t'(cfg_index))
                qvr_pkg::REG_QUAT_W: quat_w_reg <= $signed(cfg_data);
                qvr_pkg::REG_QUAT_X: quat_x_reg <= $signed(cfg_data);
                qvr_pkg::REG_QUAT_Y: quat_y_reg <= $signed(cfg_data);
                qvr_pkg::REG_QUAT_Z: quat_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Advance all stages unless the output word is held
    assign advance      = !valid_reg[NS-1] || rot_out.ready;
    assign vec_in.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NS-2:0], vec_in.valid};
        end
    end

    // Stage 1: products of q and v
    always_comb
    begin
        p_next[0]  = PW'(quat_x_reg) * PW'(vec_in.vec_x);
        p_next[1]  = PW'(quat_y_reg) * PW'(vec_in.vec_y);
        p_next[2]  = PW'(quat_z_reg) * PW'(vec_in.vec_z);
        p_next[3]  = PW'(quat_w_reg) * PW'(vec_in.vec_x);
        p_next[4]  = PW'(quat_y_reg) * PW'(vec_in.vec_z);
        p_next[5]  = PW'(quat_z_reg) * PW'(vec_in.vec_y);
        p_next[6]  = PW'(quat_w_reg) * PW'(vec_in.vec_y);
        p_next[7]  = PW'(quat_x_reg) * PW'(vec_in.vec_z);
        p_next[8]  = PW'(quat_z_reg) * PW'(vec_in.vec_x);
        p_next[9]  = PW'(quat_w_reg) * PW'(vec_in.vec_z);
        p_next[10] = PW'(quat_x_reg) * PW'(vec_in.vec_y);
        p_next[11] = PW'(quat_y_reg) * PW'(vec_in.vec_x);
    end

    // Stage 2: t = q * (0, v)
    always_comb
    begin
        t_next[0] = -TW'(p_reg[0]) - TW'(p_reg[1]) - TW'(p_reg[2]);
        t_next[1] =  TW'(p_reg[3]) + TW'(p_reg[4]) - TW'(p_reg[5]);
        t_next[2] =  TW'(p_reg[6]) - TW'(p_reg[7]) + TW'(p_reg[8]);
        t_next[3] =  TW'(p_reg[9]) + TW'(p_reg[10]) - TW'(p_reg[11]);
    end

    // Stage 3: products of t and conj(q)
    always_comb
    begin
        m_next[0]  = RW'(t_reg[0]) * RW'(quat_x_reg);
        m_next[1]  = RW'(t_reg[1]) * RW'(quat_w_reg);
        m_next[2]  = RW'(t_reg[2]) * RW'(quat_z_reg);
        m_next[3]  = RW'(t_reg[3]) * RW'(quat_y_reg);
        m_next[4]  = RW'(t_reg[0]) * RW'(quat_y_reg);
        m_next[5]  = RW'(t_reg[1]) * RW'(quat_z_reg);
        m_next[6]  = RW'(t_reg[2]) * RW'(quat_w_reg);
        m_next[7]  = RW'(t_reg[3]) * RW'(quat_x_reg);
        m_next[8]  = RW'(t_reg[0]) * RW'(quat_z_reg);
        m_next[9]  = RW'(t_reg[1]) * RW'(quat_y_reg);
        m_next[10] = RW'(t_reg[2]) * RW'(quat_x_reg);
        m_next[11] = RW'(t_reg[3]) * RW'(quat_w_reg);
    end

    // Stage 4: vector part of t * conj(q), with the rounding half folded in
    always_comb
    begin
        acc_next[0] = HALF - AW'(m_reg[0]) + AW'(m_reg[1]) - AW'(m_reg[2])
                      + AW'(m_reg[3]);
        acc_next[1] = HALF - AW'(m_reg[4]) + AW'(m_reg[5]) + AW'(m_reg[6])
                      - AW'(m_reg[7]);
        acc_next[2] = HALF - AW'(m_reg[8]) - AW'(m_reg[9]) + AW'(m_reg[10])
                      + AW'(m_reg[11]);
    end

    // Stage 5: drop the fraction and saturate each component
    always_comb
    begin
        logic signed [SW-1:0] shifted;
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            shifted = acc_reg[i][AW-1:qvr_pkg::FRAC_SHIFT];
            if (shifted > SAT_MAX)
            begin
                rot_next[i] = DATA_WIDTH'(SAT_MAX);
                clip_next   = 1'b1;
            end
            else if (shifted < SAT_MIN)
            begin
                rot_next[i] = DATA_WIDTH'(SAT_MIN);
                clip_next   = 1'b1;
            end
            else
            begin
                rot_next[i] = shifted[DATA_WIDTH-1:0];
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg    <= p_next;
            t_reg    <= t_next;
            m_reg    <= m_next;
            acc_reg  <= acc_next;
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
            w_reg[0] <= vec_in.vec_w;
            for (int i = 1; i < NS; i++)
            begin
                w_reg[i] <= w_reg[i-1];
            end
        end
    end

    // Drive the output word
    assign rot_out.valid   = valid_reg[NS-1];
    assign rot_out.rot_x   = rot_reg[0];
    assign rot_out.rot_y   = rot_reg[1];
    assign rot_out.rot_z   = rot_reg[2];
    assign rot_out.pass_w  = w_reg[NS-1];
    assign rot_out.clipped = clip_reg;

endmodule

/* rtl/qvr_checker.sv */
// qvr_checker: port-level assertions for quaternion_vector_rotate.
// Depends on quaternion_vector_rotate; attached through the bind below.
module qvr_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] rot_x,
    input logic signed [DATA_WIDTH-1:0] rot_y,
    input logic signed [DATA_WIDTH-1:0] rot_z,
    input logic                         clipped
);

    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Hold a word that is not taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("rot_out dropped a stalled word");

    // Keep the stalled word stable
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
                                    && $stable(clipped))
        else $error("rot_out payload changed during a stall");

    // Back-pressure only comes from a held output word
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("vec_in stalled without output back-pressure");

    // A clipped word has some component at a range limit
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> rot_x == MAXV || rot_x == MINV || rot_y == MAXV
                                 || rot_y == MINV || rot_z == MAXV || rot_z == MINV)
        else $error("clipped set with no saturated component");

endmodule

bind quaternion_vector_rotate qvr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vec_in.ready),
    .out_valid (rot_out.valid),
    .out_ready (rot_out.ready),
    .rot_x     (rot_out.rot_x),
    .rot_y     (rot_out.rot_y),
    .rot_z     (rot_out.rot_z),
    .clipped   (rot_out.clipped)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for quaternion_vector_rotate (q * v * conj(q)).
// Depends on qvr_pkg, qvr_in_if, qvr_out_if and the block itself; drives a directed
// table, then random phases under several quaternions, checked by a local predictor.
module tb_top;

    localparam int DATA_WIDTH     = 16;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_WORDS    = 93;
    localparam int PRESSURE_PHASE = 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
        logic signed [DATA_WIDTH-1:0] w;
    } vec_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
        logic signed [DATA_WIDTH-1:0] w;
        logic                         clipped;
    } rot_word_t;

    typedef enum {ROW_CFG, ROW_VEC, ROW_VEC_KNOWN} row_kind_t;

    // One row of the directed table: a register write, or a vector with or
    // without a hand-written result (rot_x, rot_y, rot_z, pass_w, clipped)
    typedef struct {
        row_kind_t kind;
        int        vals[4];
        int        res[5];
    } dir_row_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index;
    logic [qvr_pkg::QUAT_WIDTH-1:0]        cfg_data;

    qvr_in_if  #(.DATA_WIDTH(DATA_WIDTH)) vec_in ();
    qvr_out_if #(.DATA_WIDTH(DATA_WIDTH)) rot_out ();

    quaternion_vector_rotate #(.DATA_WIDTH(DATA_WIDTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vec_in    (vec_in),
        .rot_out   (rot_out)
    );

    // Local copy of the quaternion registers (w, x, y, z)
    logic signed [qvr_pkg::QUAT_WIDTH-1:0] quat_regs [4];
    rot_word_t                             pending_rotations [$];
    int                                    fail_count    = 0;
    int                                    cycle_count   = 0;
    int                                    src_idle_pct  = 34;
    int                                    sink_idle_pct = 76;
    int                                    phase_num     = -1;

    always #5 clk = ~clk;

    // Rotate one vector by the mirrored quaternion, round and saturate
    function automatic rot_word_t rotate_vector(vec_word_t v);
        longint    qw, qx, qy, qz, vx, vy, vz;
        longint    tw, tx, ty, tz, s;
        longint    acc[3];
        longint    maxv, minv;
        rot_word_t r;
        qw = quat_regs[qvr_pkg::REG_QUAT_W];
        qx = quat_regs[qvr_pkg::REG_QUAT_X];
        qy = quat_regs[qvr_pkg::REG_QUAT_Y];
        qz = quat_regs[qvr_pkg::REG_QUAT_Z];
        vx = v.x;
        vy = v.y;
        vz = v.z;
        maxv = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        minv = -maxv - 1;
        // q * (0, v)
        tw = -qx * vx - qy * vy - qz * vz;
        tx =  qw * vx + qy * vz - qz * vy;
        ty =  qw * vy - qx * vz + qz * vx;
        tz =  qw * vz + qx * vy - qy * vx;
        // t * conj(q), vector part only
        acc[0] = -tw * qx + tx * qw - ty * qz + tz * qy;
        acc[1] = -tw * qy + tx * qz + ty * qw - tz * qx;
        acc[2] = -tw * qz - tx * qy + ty * qx + tz * qw;
        r.clipped = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            s = (acc[i] + (longint'(1) <<< (qvr_pkg::FRAC_SHIFT - 1))) >>> qvr_pkg::FRAC_SHIFT;
            if (s > maxv)
            begin
                s = maxv;
                r.clipped = 1'b1;
            end
            else if (s < minv)
            begin
                s = minv;
                r.clipped = 1'b1;
            end
            case (i)
                0: r.x = s[DATA_WIDTH-1:0];
                1: r.y = s[DATA_WIDTH-1:0];
                default: r.z = s[DATA_WIDTH-1:0];
            endcase
        end
        r.w = v.w;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(qvr_pkg::cfg_reg_t idx, int value);
        dir_row_t row;
        row.kind = ROW_CFG;
        row.vals = '{int'(idx), value, 0, 0};
        row.res  = '{0, 0, 0, 0, 0};
        return row;
    endfunction

    function automatic dir_row_t vec_row(int x, int y, int z, int w);
        dir_row_t row;
        row.kind = ROW_VEC;
        row.vals = '{x, y, z, w};
        row.res  = '{0, 0, 0, 0, 0};
        return row;
    endfunction

    function automatic dir_row_t known_row(int x, int y, int z, int w,
                                           int rx, int ry, int rz, int rw, int clip);
        dir_row_t row;
        row.kind = ROW_VEC_KNOWN;
        row.vals = '{x, y, z, w};
        row.res  = '{rx, ry, rz, rw, clip};
        return row;
    endfunction

    // Directed table: identity, zero quaternion, pure scaling, axis rotations,
    // exact half turn, and all-extreme quaternions
    dir_row_t dir_table [] = '{
        // identity after reset: words pass unchanged
        known_row(0, 0, 0, 0,                    0, 0, 0, 0, 0),
        known_row(32767, -32768, 1, -1,          32767, -32768, 1, -1, 0),
        known_row(-32768, 32767, -1, 32767,      -32768, 32767, -1, 32767, 0),
        known_row(-21846, 21845, 0, 1234,        -21846, 21845, 0, 1234, 0),
        // zero quaternion: everything collapses to zero
        cfg_row(qvr_pkg::REG_QUAT_W, 0),
        known_row(32767, 32767, -32768, 5,       0, 0, 0, 5, 0),
        known_row(-32768, -32768, -32768, -32768, 0, 0, 0, -32768, 0),
        // w = -2.0 scales by four and saturates
        cfg_row(qvr_pkg::REG_QUAT_W, -32768),
        known_row(100, -200, 300, 0,             400, -800, 1200, 0, 0),
        known_row(10000, -10000, 0, 7,           32767, -32768, 0, 7, 1),
        known_row(-32768, 32767, 1, -32768,      -32768, 32767, 4, -32768, 1),
        cfg_row(qvr_pkg::REG_QUAT_W, 32767),
        vec_row(8191, -8192, 1, 0),
        // quarter turn about z
        cfg_row(qvr_pkg::REG_QUAT_W, 11585),
        cfg_row(qvr_pkg::REG_QUAT_Z, 11585),
        vec_row(1000, 0, 0, 0),
        vec_row(0, 1000, 0, 0),
        vec_row(0, 0, 1000, 0),
        // quarter turn about x
        cfg_row(qvr_pkg::REG_QUAT_Z, 0),
        cfg_row(qvr_pkg::REG_QUAT_X, 11585),
        vec_row(0, 1000, 0, 0),
        vec_row(32767, -32768, 32767, 0),
        // half turn about y: x and z negate, -32768 saturates
        cfg_row(qvr_pkg::REG_QUAT_W, 0),
        cfg_row(qvr_pkg::REG_QUAT_X, 0),
        cfg_row(qvr_pkg::REG_QUAT_Y, 16384),
        known_row(123, -456, 789, 9,             -123, -456, -789, 9, 0),
        known_row(-32768, 5, -5, 0,              32767, 5, 5, 0, 1),
        // all components at the negative limit
        cfg_row(qvr_pkg::REG_QUAT_W, -32768),
        cfg_row(qvr_pkg::REG_QUAT_X, -32768),
        cfg_row(qvr_pkg::REG_QUAT_Y, -32768),
        cfg_row(qvr_pkg::REG_QUAT_Z, -32768),
        vec_row(32767, -32768, 32767, -1),
        vec_row(1, 1, 1, 1),
        // all components at the positive limit
        cfg_row(qvr_pkg::REG_QUAT_W, 32767),
        cfg_row(qvr_pkg::REG_QUAT_X, 32767),
        cfg_row(qvr_pkg::REG_QUAT_Y, 32767),
        cfg_row(qvr_pkg::REG_QUAT_Z, 32767),
        vec_row(-32768, -32768, -32768, 32767),
        vec_row(0, 0, 0, 0)
    };

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Write one register while the block is idle, and mirror it
    task automatic write_reg(qvr_pkg::cfg_reg_t idx, logic [qvr_pkg::QUAT_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        quat_regs[idx] = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word, with random gaps in front, and record what it must give
    task automatic send_vector(vec_word_t v, bit known, rot_word_t known_res);
        while ($urandom_range(99) < src_idle_pct)
        begin
            vec_in.valid <= 1'b0;
            @(posedge clk);
        end
        vec_in.valid <= 1'b1;
        vec_in.vec_x <= v.x;
        vec_in.vec_y <= v.y;
        vec_in.vec_z <= v.z;
        vec_in.vec_w <= v.w;
        @(posedge clk);
        while (!vec_in.ready)
            @(posedge clk);
        pending_rotations.push_back(known ? known_res : rotate_vector(v));
    endtask

    // Stop offering and wait until the pipeline is empty
    task automatic drain();
        vec_in.valid <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (qvr_pkg::PIPE_STAGES) @(posedge clk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_field();
        case ($urandom_range(7))
            0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            1, 2:    return 16'(int'($urandom_range(1024)) - 512);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [qvr_pkg::QUAT_WIDTH-1:0] pick_quat_part(int kind);
        case (kind)
            0: return 16'($urandom_range(65535));
            1: return 16'(int'($urandom_range(18000)) - 9000);
            2: return 16'(int'($urandom_range(23170)) - 11585);
            default:
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'd16384;
                endcase
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rot_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && phase_num == PRESSURE_PHASE)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rot_out.ready <= 1'b0;
            end
            else
            begin
                rot_out.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Check each output word against the oldest expectation
    always @(posedge clk)
    begin
        rot_word_t got;
        rot_word_t want;
        if (rst_n === 1'b1 && rot_out.valid === 1'b1 && rot_out.ready === 1'b1)
        begin
            got.x       = rot_out.rot_x;
            got.y       = rot_out.rot_y;
            got.z       = rot_out.rot_z;
            got.w       = rot_out.pass_w;
            got.clipped = rot_out.clipped;
            if (pending_rotations.size() == 0)
            begin
                note_failure($sformatf("unexpected word: rot=(%0d,%0d,%0d) w=%0d clip=%0b",
                             got.x, got.y, got.z, got.w, got.clipped));
            end
            else
            begin
                want = pending_rotations.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.w !== want.w || got.clipped !== want.clipped)
                    note_failure($sformatf(
                        "mismatch: want %0d %0d %0d w=%0d c=%0b, got %0d %0d %0d w=%0d c=%0b",
                        want.x, want.y, want.z, want.w, want.clipped,
                        got.x, got.y, got.z, got.w, got.clipped));
            end
        end
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        vec_word_t v;
        rot_word_t r;
        int        kind;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = qvr_pkg::REG_QUAT_W;
        cfg_data     = '0;
        vec_in.valid = 1'b0;
        vec_in.vec_x = '0;
        vec_in.vec_y = '0;
        vec_in.vec_z = '0;
        vec_in.vec_w = '0;
        quat_regs[qvr_pkg::REG_QUAT_W] = qvr_pkg::QUAT_W_RESET;
        quat_regs[qvr_pkg::REG_QUAT_X] = qvr_pkg::QUAT_V_RESET;
        quat_regs[qvr_pkg::REG_QUAT_Y] = qvr_pkg::QUAT_V_RESET;
        quat_regs[qvr_pkg::REG_QUAT_Z] = qvr_pkg::QUAT_V_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; register writes only on an empty pipeline
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(qvr_pkg::cfg_reg_t'(dir_table[i].vals[0]),
                          16'(dir_table[i].vals[1]));
            end
            else
            begin
                v.x = 16'(dir_table[i].vals[0]);
                v.y = 16'(dir_table[i].vals[1]);
                v.z = 16'(dir_table[i].vals[2]);
                v.w = 16'(dir_table[i].vals[3]);
                r.x = 16'(dir_table[i].res[0]);
                r.y = 16'(dir_table[i].res[1]);
                r.z = 16'(dir_table[i].res[2]);
                r.w = 16'(dir_table[i].res[3]);
                r.clipped = dir_table[i].res[4][0];
                send_vector(v, dir_table[i].kind == ROW_VEC_KNOWN, r);
            end
        end

        // Random phases, each under a fresh quaternion and one of three idle patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p < 4)
            begin
                src_idle_pct  = 34;
                sink_idle_pct = 76;
            end
            else if (p < 7)
            begin
                src_idle_pct  = 76;
                sink_idle_pct = 34;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            kind = p % 4;
            write_reg(qvr_pkg::REG_QUAT_W, pick_quat_part(kind));
            write_reg(qvr_pkg::REG_QUAT_X, pick_quat_part(kind));
            write_reg(qvr_pkg::REG_QUAT_Y, pick_quat_part(kind));
            write_reg(qvr_pkg::REG_QUAT_Z, pick_quat_part(kind));
            phase_num = p;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                v.x = pick_field();
                v.y = pick_field();
                v.z = pick_field();
                v.w = 16'($urandom_range(65535));
                send_vector(v, 1'b0, '0);
            end
        end

        drain();
        repeat (4 * qvr_pkg::PIPE_STAGES) @(posedge clk);
        if (pending_rotations.size() != 0)
            note_failure($sformatf("%0d expected words never arrived",
                         pending_rotations.size()));
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* quaternion_vector_rotate.f */
rtl/qvr_pkg.sv
rtl/qvr_in_if.sv
rtl/qvr_out_if.sv
rtl/quaternion_vector_rotate.sv
rtl/qvr_checker.sv
sim/tb_top.sv
